// ===== rtl/lzd_pkg.sv =====
// Shared types and constants of the LZ77 type 0x10 stream decompressor.
package lzd_pkg;

   // History window geometry
   localparam int unsigned HIST_AW    = 12;
   localparam int unsigned HIST_DEPTH = 1 << HIST_AW;

   // Stream format constants
   localparam logic [7:0] TYPE_BYTE      = 8'h10;
   localparam logic [4:0] LEN_BIAS       = 5'd3;
   localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

   // Input item: one byte of the compressed stream
   typedef struct packed {
      logic       start_req;
      logic [7:0] data_byte;
   } req_payload_type;

   // Result item: one decompressed byte
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } rsp_payload_type;

   // Commands from the sequencer to the history window
   typedef struct packed {
      logic               wr_en;
      logic               rd_en;
      logic [7:0]         wr_data;
      logic [HIST_AW-1:0] rd_dist;
   } hist_cmd_type;

endpackage

// ===== rtl/lzd_hist.sv =====
// History window: 4096-byte memory with write pointer, distance read and fill tracking.
module lzd_hist import lzd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  hist_cmd_type cmd,
   output logic [7:0]   rd_data
);

   logic [7:0]         mem [HIST_DEPTH];
   logic [HIST_AW-1:0] wp_ff;
   logic [HIST_AW-1:0] wp_in;
   logic               wrapped_ff;
   logic               wrapped_in;
   logic [HIST_AW-1:0] rd_addr;
   logic [7:0]         rd_data_ff;
   logic               rd_hit_ff;

   // Source address: write pointer minus distance, modulo window size
   assign rd_addr = wp_ff - cmd.rd_dist;

   // Write pointer advances on every stored byte; wrapped marks a full window
   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (cmd.wr_en) begin
         wp_in = wp_ff + HIST_AW'(1);
         if (wp_ff == '1) begin
            wrapped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   // Memory port: one write at the pointer, one registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wp_ff] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_hit_ff  <= wrapped_ff || (rd_addr < wp_ff);
      end
   end

   // Entries not yet written since reset read as zero
   assign rd_data = rd_hit_ff ? rd_data_ff : 8'd0;

endmodule

// ===== rtl/lzd_out_stage.sv =====
// Result output register with valid/stall handshake.
module lzd_out_stage import lzd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rsp_payload_type load_data,
   output logic            free,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type data_ff;
   rsp_payload_type data_in;

   // Slot can take a new result when empty or when its transfer completes now
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = load || (valid_ff && rsp_stall);
      data_in  = load ? load_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/lz77_stream_decompressor_unit.sv =====
// Top level: LZ77 type 0x10 stream decompressor with stream parser and copy sequencer.
//
// Usage:
//   req_* takes the compressed stream one byte per transfer; start_req marks the type
//   byte of a new stream, which also drops any stream in progress. rsp_* delivers one
//   decompressed byte per transfer, last set on the final byte of the stream. A bad
//   type byte gives one result with error and last set and out_byte zero.
// Timing:
//   Header, flag and reference high bytes are only taken in, with no further step. A literal
//   is accepted, then stored in the history window and loaded into the output register. A
//   back reference is accepted, then each copied byte takes a window read and then a write
//   and output load, since every byte goes through the single window port pair. A literal
//   or bad type result reaches rsp_valid via the ST_LIT or ST_ERR step and the output
//   register, the first copied byte via ST_RD, ST_CP and the output register.
// Reset:
//   Synchronous, active high. The block comes up idle, waiting for a start byte. The
//   history window is not swept; bytes never written since reset read as zero.
// Backpressure:
//   A result waits in the output register while rsp_stall is high; the sequencer then
//   holds its current byte and req_stall stays high until it can move on.
module lz77_stream_decompressor_unit import lzd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   // Sequencer steps
   typedef enum logic [4:0] {
      ST_IN  = 5'b00001,
      ST_LIT = 5'b00010,
      ST_ERR = 5'b00100,
      ST_RD  = 5'b01000,
      ST_CP  = 5'b10000
   } seq_type;

   // Stream parse phase
   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_HEADER  = 5'b00010,
      PH_FLAGS   = 5'b00100,
      PH_TOKEN   = 5'b01000,
      PH_REF_LOW = 5'b10000
   } phase_type;

   seq_type            seq_ff, seq_in;
   phase_type          phase_ff, phase_in;
   logic [1:0]         hdr_idx_ff, hdr_idx_in;
   logic [23:0]        rem_ff, rem_in;
   logic [7:0]         flag_bits_ff, flag_bits_in;
   logic [3:0]         flags_left_ff, flags_left_in;
   logic [7:0]         tok_hi_ff, tok_hi_in;
   logic [7:0]         lit_ff, lit_in;
   logic [HIST_AW-1:0] dist_ff, dist_in;
   logic [4:0]         count_ff, count_in;

   hist_cmd_type       cmd;
   logic [7:0]         hist_rd_data;
   logic               out_free;
   logic               out_load;
   rsp_payload_type    out_data;

   logic [23:0]        hdr_placed;
   logic [23:0]        hdr_rem;
   logic [23:0]        rem_dec;
   logic               rem_done;
   logic [3:0]         flags_dec;
   logic [7:0]         emit_byte;
   phase_type          fin_phase;
   logic [7:0]         fin_flag_bits;
   logic [3:0]         fin_flags_left;

   // Window memory
   lzd_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (hist_rd_data)
   );

   // Output register
   lzd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (out_data),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = (seq_ff != ST_IN);

   // Size header: place each byte little-endian
   always_comb begin
      unique case (hdr_idx_ff)
         2'd0:    hdr_placed = {16'd0, req_data.data_byte};
         2'd1:    hdr_placed = {8'd0, req_data.data_byte, 8'd0};
         2'd2:    hdr_placed = {req_data.data_byte, 16'd0};
         default: hdr_placed = 24'd0;
      endcase
   end
   assign hdr_rem = rem_ff | hdr_placed;

   // Shared countdown on the remaining size
   assign rem_dec   = rem_ff - 24'd1;
   assign rem_done  = (rem_dec == 24'd0);
   assign flags_dec = flags_left_ff - 4'd1;
   assign emit_byte = (seq_ff == ST_LIT) ? lit_ff : hist_rd_data;

   // End of token: move to next flag bit, or go idle once the size is reached
   always_comb begin
      fin_flag_bits  = flag_bits_ff;
      fin_flags_left = flags_left_ff;
      fin_phase      = PH_IDLE;
      if (!rem_done) begin
         fin_flag_bits  = {flag_bits_ff[6:0], 1'b0};
         fin_flags_left = flags_dec;
         fin_phase      = (flags_dec != 4'd0) ? PH_TOKEN : PH_FLAGS;
      end
   end

   // Sequencer and parser
   always_comb begin
      seq_in        = seq_ff;
      phase_in      = phase_ff;
      hdr_idx_in    = hdr_idx_ff;
      rem_in        = rem_ff;
      flag_bits_in  = flag_bits_ff;
      flags_left_in = flags_left_ff;
      tok_hi_in     = tok_hi_ff;
      lit_in        = lit_ff;
      dist_in       = dist_ff;
      count_in      = count_ff;
      cmd           = '0;
      out_load      = 1'b0;
      out_data      = '0;

      unique case (seq_ff)
         ST_IN: begin
            if (req_valid) begin
               if (req_data.start_req) begin
                  hdr_idx_in    = 2'd0;
                  rem_in        = 24'd0;
                  flag_bits_in  = 8'd0;
                  flags_left_in = 4'd0;
                  if (req_data.data_byte != TYPE_BYTE) begin
                     phase_in = PH_IDLE;
                     seq_in   = ST_ERR;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end else begin
                  unique case (phase_ff)
                     PH_IDLE: begin
                        phase_in = PH_IDLE;
                     end
                     PH_HEADER: begin
                        rem_in     = hdr_rem;
                        hdr_idx_in = hdr_idx_ff + 2'd1;
                        if (hdr_idx_ff == 2'd2) begin
                           hdr_idx_in = 2'd0;
                           phase_in   = (hdr_rem != 24'd0) ? PH_FLAGS : PH_IDLE;
                        end
                     end
                     PH_FLAGS: begin
                        flag_bits_in  = req_data.data_byte;
                        flags_left_in = FLAGS_PER_BYTE;
                        phase_in      = PH_TOKEN;
                     end
                     PH_TOKEN: begin
                        if (flag_bits_ff[7]) begin
                           tok_hi_in = req_data.data_byte;
                           phase_in  = PH_REF_LOW;
                        end else begin
                           lit_in = req_data.data_byte;
                           seq_in = ST_LIT;
                        end
                     end
                     PH_REF_LOW: begin
                        dist_in  = {tok_hi_ff[3:0], req_data.data_byte} + 12'd1;
                        count_in = {1'b0, tok_hi_ff[7:4]} + LEN_BIAS;
                        seq_in   = ST_RD;
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               out_load       = 1'b1;
               out_data.error = 1'b1;
               out_data.last  = 1'b1;
               seq_in         = ST_IN;
            end
         end
         ST_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_dist = dist_ff;
            seq_in      = ST_CP;
         end
         ST_LIT, ST_CP: begin
            if (out_free) begin
               cmd.wr_en         = 1'b1;
               cmd.wr_data       = emit_byte;
               out_load          = 1'b1;
               out_data.out_byte = emit_byte;
               out_data.last     = rem_done;
               rem_in            = rem_dec;
               count_in          = count_ff - 5'd1;
               if ((seq_ff == ST_LIT) || (count_ff == 5'd1) || rem_done) begin
                  phase_in      = fin_phase;
                  flag_bits_in  = fin_flag_bits;
                  flags_left_in = fin_flags_left;
                  seq_in        = ST_IN;
               end else begin
                  seq_in = ST_RD;
               end
            end
         end
         default: begin
            seq_in = ST_IN;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= ST_IN;
         phase_ff      <= PH_IDLE;
         hdr_idx_ff    <= 2'd0;
         rem_ff        <= 24'd0;
         flag_bits_ff  <= 8'd0;
         flags_left_ff <= 4'd0;
         tok_hi_ff     <= 8'd0;
      end else begin
         seq_ff        <= seq_in;
         phase_ff      <= phase_in;
         hdr_idx_ff    <= hdr_idx_in;
         rem_ff        <= rem_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         tok_hi_ff     <= tok_hi_in;
      end
   end

   // Token payload
   always_ff @(posedge clock) begin
      lit_ff   <= lit_in;
      dist_ff  <= dist_in;
      count_ff <= count_in;
   end

endmodule
